FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define RBE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbe assertion failed");

// next-cycle implication, clocked on clk, off while in reset
`define RBE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbe assertion failed");

`endif

FILE: hdl/rbe_pkg.sv
`default_nettype none

package rbe_pkg;

    localparam int CW_DEFAULT = 32;
    localparam int ANG_W      = 34;
    localparam int ATAN_STEPS = 30;
    localparam int NORM_STEPS = 5;
    localparam int ATAN_LAT   = 2 * NORM_STEPS + ATAN_STEPS + 2;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_LAT    = 33;
    localparam int DEN_W      = 37;

    localparam logic signed [ANG_W-1:0] TURN_HALF    = 34'sd2147483648;
    localparam logic signed [ANG_W-1:0] TURN_QUARTER = 34'sd1073741824;

    typedef struct packed {
        logic [3:0] ge;
        logic [3:0] le;
        logic       corner;
        logic       rzero;
    } edge_flags_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] cordic_tab(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051E;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2F;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2FA;
            15: t = 32'h0000517D;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A30;
            19: t = 32'h00000518;
            20: t = 32'h0000028C;
            21: t = 32'h00000146;
            22: t = 32'h000000A3;
            23: t = 32'h00000051;
            24: t = 32'h00000029;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000003;
            29: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rbe_delay.sv
`default_nettype none

module rbe_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         ce,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [0:N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (ce)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];

endmodule

`default_nettype wire

FILE: hdl/rbe_isqrt.sv
`default_nettype none

module rbe_isqrt (
    input  logic        clk,
    input  logic        ce,
    input  logic [63:0] v_in,
    output logic [31:0] root
);

    import rbe_pkg::*;

    logic [63:0] v_reg    [0:SQRT_STEPS-1];
    logic [63:0] r_reg    [0:SQRT_STEPS-1];
    logic [63:0] v_next   [0:SQRT_STEPS-1];
    logic [63:0] r_next   [0:SQRT_STEPS-1];

    always_comb
    begin
        logic [63:0] pv;
        logic [63:0] pr;
        logic [63:0] b;
        logic [63:0] t;
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            pv = (k == 0) ? v_in : v_reg[(k == 0) ? 0 : k - 1];
            pr = (k == 0) ? 64'd0 : r_reg[(k == 0) ? 0 : k - 1];
            b  = 64'd1 << (62 - 2 * k);
            t  = pr + b;
            if (pv >= t)
            begin
                v_next[k] = pv - t;
                r_next[k] = (pr >> 1) + b;
            end
            else
            begin
                v_next[k] = pv;
                r_next[k] = pr >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][31:0];

endmodule

`default_nettype wire

FILE: hdl/rbe_atan2.sv
`default_nettype none

module rbe_atan2 #(
    parameter int AW = 33
) (
    input  logic                              clk,
    input  logic                              ce,
    input  logic signed [AW-1:0]              x_in,
    input  logic signed [AW-1:0]              y_in,
    output logic signed [rbe_pkg::ANG_W-1:0]  angle
);

    import rbe_pkg::*;

    localparam int W   = (AW + 1 > 32) ? AW + 1 : 32;
    localparam int NN  = 2 * NORM_STEPS;
    localparam int CXW = 34;

    logic signed [W-1:0]     xe, ye, xf, yf, ay;
    logic [W-1:0]            mf;
    logic signed [ANG_W-1:0] basef;

    logic signed [W-1:0]     x_n_reg    [0:NN];
    logic signed [W-1:0]     y_n_reg    [0:NN];
    logic [W-1:0]            m_n_reg    [0:NN];
    logic signed [ANG_W-1:0] base_n_reg [0:NN];
    logic                    zero_n_reg [0:NN];
    logic                    dn_c       [0:NORM_STEPS-1];
    logic                    up_c       [0:NORM_STEPS-1];

    logic signed [CXW-1:0]   cx_reg     [0:ATAN_STEPS-1];
    logic signed [CXW-1:0]   cy_reg     [0:ATAN_STEPS-1];
    logic signed [ANG_W-1:0] cz_reg     [0:ATAN_STEPS-1];
    logic signed [ANG_W-1:0] base_c_reg [0:ATAN_STEPS-1];
    logic                    zero_c_reg [0:ATAN_STEPS-1];
    logic signed [CXW-1:0]   cx_next    [0:ATAN_STEPS-1];
    logic signed [CXW-1:0]   cy_next    [0:ATAN_STEPS-1];
    logic signed [ANG_W-1:0] cz_next    [0:ATAN_STEPS-1];

    // fold into the right half plane
    always_comb
    begin
        xe = W'(x_in);
        ye = W'(y_in);
        xf = x_in[AW-1] ? -xe : xe;
        yf = x_in[AW-1] ? -ye : ye;
        ay = yf[W-1] ? -yf : yf;
        mf = (xf > ay) ? xf : ay;
        basef = '0;
        if (x_in[AW-1])
        begin
            basef = y_in[AW-1] ? -TURN_HALF : TURN_HALF;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NORM_STEPS; k++)
        begin
            dn_c[k] = 64'(m_n_reg[k]) >= (64'd1 << (29 + (16 >> k)));
            up_c[k] = (64'(m_n_reg[NORM_STEPS+k]) << (16 >> k)) < (64'd1 << 30);
        end
    end

    always_comb
    begin
        logic signed [CXW-1:0]   px;
        logic signed [CXW-1:0]   py;
        logic signed [ANG_W-1:0] pz;
        logic signed [ANG_W-1:0] tab;
        for (int i = 0; i < ATAN_STEPS; i++)
        begin
            if (i == 0)
            begin
                px = CXW'(signed'(x_n_reg[NN][31:0]));
                py = CXW'(signed'(y_n_reg[NN][31:0]));
                pz = '0;
            end
            else
            begin
                px = cx_reg[(i == 0) ? 0 : i - 1];
                py = cy_reg[(i == 0) ? 0 : i - 1];
                pz = cz_reg[(i == 0) ? 0 : i - 1];
            end
            tab = signed'(ANG_W'(cordic_tab(i)));
            if (py > 0)
            begin
                cx_next[i] = px + (py >>> i);
                cy_next[i] = py - (px >>> i);
                cz_next[i] = pz + tab;
            end
            else
            begin
                cx_next[i] = px - (py >>> i);
                cy_next[i] = py + (px >>> i);
                cz_next[i] = pz - tab;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_n_reg[0]    <= xf;
            y_n_reg[0]    <= yf;
            m_n_reg[0]    <= mf;
            base_n_reg[0] <= basef;
            zero_n_reg[0] <= (mf == '0);
            // scale down until below 2^30
            for (int k = 0; k < NORM_STEPS; k++)
            begin
                x_n_reg[k+1]    <= dn_c[k] ? (x_n_reg[k] >>> (16 >> k)) : x_n_reg[k];
                y_n_reg[k+1]    <= dn_c[k] ? (y_n_reg[k] >>> (16 >> k)) : y_n_reg[k];
                m_n_reg[k+1]    <= dn_c[k] ? (m_n_reg[k] >> (16 >> k)) : m_n_reg[k];
                base_n_reg[k+1] <= base_n_reg[k];
                zero_n_reg[k+1] <= zero_n_reg[k];
            end
            // scale up until at least 2^29
            for (int k = 0; k < NORM_STEPS; k++)
            begin
                x_n_reg[NORM_STEPS+k+1] <= up_c[k] ?
                    (x_n_reg[NORM_STEPS+k] <<< (16 >> k)) : x_n_reg[NORM_STEPS+k];
                y_n_reg[NORM_STEPS+k+1] <= up_c[k] ?
                    (y_n_reg[NORM_STEPS+k] <<< (16 >> k)) : y_n_reg[NORM_STEPS+k];
                m_n_reg[NORM_STEPS+k+1] <= up_c[k] ?
                    (m_n_reg[NORM_STEPS+k] << (16 >> k)) : m_n_reg[NORM_STEPS+k];
                base_n_reg[NORM_STEPS+k+1] <= base_n_reg[NORM_STEPS+k];
                zero_n_reg[NORM_STEPS+k+1] <= zero_n_reg[NORM_STEPS+k];
            end
            base_c_reg[0] <= base_n_reg[NN];
            zero_c_reg[0] <= zero_n_reg[NN];
            for (int i = 1; i < ATAN_STEPS; i++)
            begin
                base_c_reg[i] <= base_c_reg[i-1];
                zero_c_reg[i] <= zero_c_reg[i-1];
            end
            for (int i = 0; i < ATAN_STEPS; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            angle <= zero_c_reg[ATAN_STEPS-1] ? base_c_reg[ATAN_STEPS-1] :
                     base_c_reg[ATAN_STEPS-1] + cz_reg[ATAN_STEPS-1];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rbe_div.sv
`default_nettype none

module rbe_div (
    input  logic                        clk,
    input  logic                        ce,
    input  logic [rbe_pkg::DEN_W-1:0]   den_in,
    input  logic                        sat_in,
    output logic [31:0]                 quot,
    output logic                        sat_out
);

    import rbe_pkg::*;

    localparam int RW = DEN_W + 1;
    localparam int NQ = DIV_LAT - 1;

    logic [56:0]      n_c;
    logic             over_c;

    logic [RW-1:0]    rem_reg  [0:NQ];
    logic [31:0]      lo_reg   [0:NQ];
    logic [DEN_W-1:0] den_reg  [0:NQ];
    logic [31:0]      q_reg    [0:NQ];
    logic             sat_reg  [0:NQ];
    logic [RW-1:0]    rem_next [1:NQ];
    logic             bit_next [1:NQ];

    // rounded numerator, and quotient overflow check
    always_comb
    begin
        n_c    = (57'd1 << 56) + 57'(den_in >> 1);
        over_c = 70'(n_c) >= (70'(den_in) << 32);
    end

    always_comb
    begin
        logic [RW-1:0] rem2;
        for (int k = 1; k <= NQ; k++)
        begin
            rem2 = {rem_reg[k-1][RW-2:0], lo_reg[k-1][32-k]};
            bit_next[k] = rem2 >= RW'(den_reg[k-1]);
            rem_next[k] = bit_next[k] ? rem2 - RW'(den_reg[k-1]) : rem2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= RW'(n_c[56:32]);
            lo_reg[0]  <= n_c[31:0];
            den_reg[0] <= den_in;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_in | over_c;
            for (int k = 1; k <= NQ; k++)
            begin
                rem_reg[k] <= rem_next[k];
                lo_reg[k]  <= lo_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][30:0], bit_next[k]};
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quot    = sat_reg[NQ] ? 32'hFFFFFFFF : q_reg[NQ];
    assign sat_out = sat_reg[NQ];

endmodule

`default_nettype wire

FILE: hdl/ripley_box_edge_weight.sv
// throughput: one transaction per cycle; the whole pipeline advances together and
// holds in place while the output register waits on m_tready
// the depth is set by the 32-step square root, the 42-stage atan2 and the 33-stage divider
// reset: asynchronous active low; clears valid bits and the rectangle to the unit square
`default_nettype none

`include "assert_macros.svh"

module ripley_box_edge_weight #(
    parameter int COORD_WIDTH = rbe_pkg::CW_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], pair_distance [94:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // edge_weight [31:0]
    output logic [0:0]  m_tuser,   // weight_saturated [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import rbe_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int EW = ((DW > 32) ? DW : 32) + 1;
    localparam int HW = 33;
    localparam int CY [0:7] = '{3, 2, 3, 2, 0, 1, 0, 1};
    localparam int CX [0:7] = '{0, 0, 1, 1, 3, 3, 2, 2};

    typedef enum logic [2:0] {
        CFG_X_MIN = 3'd0,
        CFG_Y_MIN = 3'd1,
        CFG_X_MAX = 3'd2,
        CFG_Y_MAX = 3'd3,
        CFG_TOL   = 3'd4
    } cfg_idx_t;

    function automatic logic signed [COORD_WIDTH-1:0] to_coord(input logic [31:0] v);
        logic [63:0] ve;
        ve = 64'(v);
        return ve[COORD_WIDTH-1:0];
    endfunction

    logic        ce;
    logic [31:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic [15:0] tol_reg;

    logic        in_vld_reg;
    logic [31:0] in_x_reg, in_y_reg;
    logic [30:0] in_r_reg;

    logic signed [COORD_WIDTH-1:0] xx, yy;
    logic signed [DW-1:0]          tol_s;
    logic signed [DW-1:0]          d_c    [0:3];
    logic [3:0]                    near_c;

    logic                 vld1_reg, corner1_reg, rzero1_reg;
    logic [30:0]          r1_reg;
    logic signed [DW-1:0] d1_reg [0:3];

    logic [3:0]           ge_c, le_c;
    logic [31:0]          rmd_c  [0:3];
    logic [31:0]          rpd_c  [0:3];

    logic                 vld2_reg;
    edge_flags_t          flags2_reg;
    logic [31:0]          rmd_reg [0:3];
    logic [31:0]          rpd_reg [0:3];
    logic signed [DW-1:0] d2_reg  [0:3];

    logic                 vld3_reg;
    edge_flags_t          flags3_reg;
    logic [63:0]          prod_reg [0:3];
    logic [4*DW-1:0]      d3_pack;
    logic [4*DW-1:0]      d4_pack;

    logic [31:0]             root     [0:3];
    logic signed [DW-1:0]    d4       [0:3];
    logic signed [ANG_W-1:0] half_ang [0:3];
    logic signed [ANG_W-1:0] cor_ang  [0:7];
    edge_flags_t             flags4;
    logic                    vld4;

    logic signed [ANG_W-1:0] ha_c     [0:3];
    logic signed [ANG_W-1:0] clip_c   [0:7];
    logic signed [ANG_W-1:0] clip_reg [0:7];
    logic                    clip_vld_reg, clip_corner_reg, clip_rzero_reg;

    logic signed [ANG_W+1:0] sa_reg, sb_reg;
    logic                    sum_vld_reg, sum_corner_reg, sum_rzero_reg;

    logic signed [ANG_W+3:0] ext_c, den_c;
    logic                    den_vld_reg, den_sat_reg;
    logic [DEN_W-1:0]        den_reg;

    logic [31:0] div_q;
    logic        div_sat, div_vld;

    logic        out_vld_reg, out_sat_reg;
    logic [31:0] out_w_reg;

    assign ce        = !out_vld_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= 32'd0;
            y_min_reg <= 32'd0;
            x_max_reg <= 32'd65536;
            y_max_reg <= 32'd65536;
            tol_reg   <= 16'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_X_MIN: x_min_reg <= cfg_data;
                CFG_Y_MIN: y_min_reg <= cfg_data;
                CFG_X_MAX: x_max_reg <= cfg_data;
                CFG_Y_MAX: y_max_reg <= cfg_data;
                CFG_TOL:   tol_reg   <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            in_x_reg <= s_tdata[31:0];
            in_y_reg <= s_tdata[63:32];
            in_r_reg <= s_tdata[94:64];
        end
    end

    // edge distances
    always_comb
    begin
        xx     = to_coord(in_x_reg);
        yy     = to_coord(in_y_reg);
        tol_s  = signed'(DW'(tol_reg));
        d_c[0] = DW'(xx) - DW'(to_coord(x_min_reg));
        d_c[1] = DW'(to_coord(x_max_reg)) - DW'(xx);
        d_c[2] = DW'(yy) - DW'(to_coord(y_min_reg));
        d_c[3] = DW'(to_coord(y_max_reg)) - DW'(yy);
        for (int k = 0; k < 4; k++)
        begin
            near_c[k] = (d_c[k] > -tol_s) && (d_c[k] < tol_s);
        end
    end

    // chord operands
    always_comb
    begin
        logic signed [EW-1:0] de;
        logic signed [EW-1:0] re;
        re = signed'(EW'(r1_reg));
        for (int k = 0; k < 4; k++)
        begin
            de       = EW'(d1_reg[k]);
            ge_c[k]  = de >= re;
            le_c[k]  = de <= -re;
            rmd_c[k] = 32'(re - de);
            rpd_c[k] = 32'(re + de);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld1_reg <= in_vld_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            corner1_reg       <= $countones(near_c) >= 2;
            rzero1_reg        <= (in_r_reg == '0);
            r1_reg            <= in_r_reg;
            flags2_reg.ge     <= ge_c;
            flags2_reg.le     <= le_c;
            flags2_reg.corner <= corner1_reg;
            flags2_reg.rzero  <= rzero1_reg;
            flags3_reg        <= flags2_reg;
            for (int k = 0; k < 4; k++)
            begin
                d1_reg[k]   <= d_c[k];
                d2_reg[k]   <= d1_reg[k];
                rmd_reg[k]  <= rmd_c[k];
                rpd_reg[k]  <= rpd_c[k];
                prod_reg[k] <= 64'(rmd_reg[k]) * 64'(rpd_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int k = 0; k < 4; k++)
            begin
                d3_pack[k*DW +: DW] <= d2_reg[k];
            end
        end
    end

    rbe_delay #(
        .W (4 * DW),
        .N (SQRT_STEPS)
    ) u_d_delay (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .d     (d3_pack),
        .q     (d4_pack)
    );

    rbe_delay #(
        .W ($bits(edge_flags_t)),
        .N (SQRT_STEPS + ATAN_LAT)
    ) u_flag_delay (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .d     (flags3_reg),
        .q     (flags4)
    );

    rbe_delay #(
        .W (1),
        .N (SQRT_STEPS + ATAN_LAT)
    ) u_vld_delay (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .d     (vld3_reg),
        .q     (vld4)
    );

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_edge
            assign d4[g] = d4_pack[g*DW +: DW];

            rbe_isqrt u_sqrt (
                .clk  (clk),
                .ce   (ce),
                .v_in (prod_reg[g]),
                .root (root[g])
            );

            rbe_atan2 #(
                .AW (HW)
            ) u_half (
                .clk   (clk),
                .ce    (ce),
                .x_in  (HW'(d4[g])),
                .y_in  (signed'({1'b0, root[g]})),
                .angle (half_ang[g])
            );
        end

        for (g = 0; g < 8; g++)
        begin : g_corner
            rbe_atan2 #(
                .AW (DW)
            ) u_corner (
                .clk   (clk),
                .ce    (ce),
                .x_in  (d4[CX[g]]),
                .y_in  (d4[CY[g]]),
                .angle (cor_ang[g])
            );
        end
    endgenerate

    // half angles with their special cases, clipped at the corner angles
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (flags4.le[k])
            begin
                ha_c[k] = TURN_HALF;
            end
            else if (flags4.ge[k])
            begin
                ha_c[k] = '0;
            end
            else
            begin
                ha_c[k] = half_ang[k];
            end
        end
        for (int c = 0; c < 8; c++)
        begin
            clip_c[c] = (ha_c[CX[c]] < cor_ang[c]) ? ha_c[CX[c]] : cor_ang[c];
        end
    end

    always_comb
    begin
        ext_c = (ANG_W+4)'(sa_reg) + (ANG_W+4)'(sb_reg)
              + (sum_corner_reg ? (ANG_W+4)'(TURN_QUARTER) : '0);
        den_c = ((ANG_W+4)'(1) <<< 32) - ext_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            den_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else if (ce)
        begin
            clip_vld_reg <= vld4;
            sum_vld_reg  <= clip_vld_reg;
            den_vld_reg  <= sum_vld_reg;
            out_vld_reg  <= div_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int c = 0; c < 8; c++)
            begin
                clip_reg[c] <= clip_c[c];
            end
            clip_corner_reg <= flags4.corner;
            clip_rzero_reg  <= flags4.rzero;
            sa_reg <= (ANG_W+2)'(clip_reg[0]) + (ANG_W+2)'(clip_reg[1])
                    + (ANG_W+2)'(clip_reg[2]) + (ANG_W+2)'(clip_reg[3]);
            sb_reg <= (ANG_W+2)'(clip_reg[4]) + (ANG_W+2)'(clip_reg[5])
                    + (ANG_W+2)'(clip_reg[6]) + (ANG_W+2)'(clip_reg[7]);
            sum_corner_reg <= clip_corner_reg;
            sum_rzero_reg  <= clip_rzero_reg;
            den_reg        <= den_c[DEN_W-1:0];
            den_sat_reg    <= sum_rzero_reg || (den_c <= 0);
            out_w_reg      <= div_q;
            out_sat_reg    <= div_sat;
        end
    end

    rbe_div u_div (
        .clk     (clk),
        .ce      (ce),
        .den_in  (den_reg),
        .sat_in  (den_sat_reg),
        .quot    (div_q),
        .sat_out (div_sat)
    );

    rbe_delay #(
        .W (1),
        .N (DIV_LAT)
    ) u_div_vld (
        .clk   (clk),
        .rst_n (rst_n),
        .ce    (ce),
        .d     (den_vld_reg),
        .q     (div_vld)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_w_reg;
    assign m_tuser  = out_sat_reg;

    `RBE_ASSERT_IMPL(a_sat_ones, out_vld_reg && out_sat_reg, out_w_reg == 32'hFFFFFFFF)
    `RBE_ASSERT_NEXT(a_stall_hold, !ce, $stable(in_vld_reg) && $stable(clip_vld_reg))
    `RBE_ASSERT_NEXT(a_out_hold, out_vld_reg && !m_tready, out_vld_reg && $stable(out_w_reg) && $stable(out_sat_reg))

endmodule

`default_nettype wire

FILE: sim/tb_ripley_box_edge_weight.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_ripley_box_edge_weight;

    localparam logic [2:0] REG_X_MIN = 3'd0;
    localparam logic [2:0] REG_Y_MIN = 3'd1;
    localparam logic [2:0] REG_X_MAX = 3'd2;
    localparam logic [2:0] REG_Y_MAX = 3'd3;
    localparam logic [2:0] REG_TOL   = 3'd4;
    localparam logic [2:0] REG_SPARE = 3'd5;

    localparam longint TURN_HALF    = 64'sh80000000;
    localparam longint TURN_QUARTER = 64'sh40000000;
    localparam longint TURN_FULL    = 64'sh100000000;
    localparam int     LIMIT        = 600000;
    localparam int     LONG_HOLD    = 320;
    localparam int     NUM_PHASES   = 6;
    localparam int     PER_PHASE    = 300;

    localparam logic [31:0] ATAN_STEP [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct {
        logic [31:0] weight;
        logic        sat;
    } weight_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [30:0] r;
        bit          typed;
        weight_t     want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    logic signed [31:0] box_x_min;
    logic signed [31:0] box_y_min;
    logic signed [31:0] box_x_max;
    logic signed [31:0] box_y_max;
    logic [15:0]        box_tol;

    weight_t pending_q[$];
    int      errors;
    int      cycles;
    int      n_items;
    int      n_results;
    int      n_sat;
    bit      quiet;
    bit      hold_req;
    int      hold_left;
    int      stall_left;

    ripley_box_edge_weight DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint cordic_angle(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint base;
        longint z;
        longint m;
        longint ay;
        longint xs;
        longint ys;
        x = x_in;
        y = y_in;
        base = 0;
        z = 0;
        if (x < 0)
        begin
            base = (y >= 0) ? TURN_HALF : -TURN_HALF;
            x = -x;
            y = -y;
        end
        ay = (y < 0) ? -y : y;
        m = (x > ay) ? x : ay;
        if (m == 0)
            return base;
        while (m >= 64'sh40000000)
        begin
            x = x >>> 1;
            y = y >>> 1;
            m = m >>> 1;
        end
        while (m < 64'sh20000000)
        begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 30; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_STEP[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_STEP[i]);
            end
        end
        return base + z;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v = v_in;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint chord_half_angle(input longint d, input longint r);
        longint unsigned s;
        if (d >= r)
            return 0;
        if (d <= -r)
            return TURN_HALF;
        s = root_floor(longint'(r - d) * longint'(r + d));
        return cordic_angle(longint'(s), d);
    endfunction

    function automatic longint lesser(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic int on_edge(input longint d, input longint tol);
        return (d > -tol && d < tol) ? 1 : 0;
    endfunction

    function automatic weight_t box_weight(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic [30:0] r_in);
        weight_t         res;
        longint          r;
        longint          tol;
        longint          dl, dr, dd, du;
        longint          al, ar, ad, au;
        longint          ext;
        longint          den;
        longint unsigned q;
        int              ncor;
        res.weight = 32'hFFFFFFFF;
        res.sat = 1'b1;
        r = longint'({33'd0, r_in});
        if (r == 0)
            return res;
        tol = longint'({48'd0, box_tol});
        dl = longint'(x) - longint'(box_x_min);
        dr = longint'(box_x_max) - longint'(x);
        dd = longint'(y) - longint'(box_y_min);
        du = longint'(box_y_max) - longint'(y);
        ncor = on_edge(dl, tol) + on_edge(dr, tol) + on_edge(dd, tol) + on_edge(du, tol);
        al = chord_half_angle(dl, r);
        ar = chord_half_angle(dr, r);
        ad = chord_half_angle(dd, r);
        au = chord_half_angle(du, r);
        ext = lesser(al, cordic_angle(du, dl)) + lesser(al, cordic_angle(dd, dl))
            + lesser(ar, cordic_angle(du, dr)) + lesser(ar, cordic_angle(dd, dr))
            + lesser(au, cordic_angle(dl, du)) + lesser(au, cordic_angle(dr, du))
            + lesser(ad, cordic_angle(dl, dd)) + lesser(ad, cordic_angle(dr, dd));
        if (ncor >= 2)
            ext = ext + TURN_QUARTER;
        den = TURN_FULL - ext;
        if (den <= 0)
            return res;
        q = ((64'd1 << 56) + longint'(den) / 2) / longint'(den);
        if (q > 64'hFFFFFFFF)
            return res;
        res.weight = q[31:0];
        res.sat = 1'b0;
        return res;
    endfunction

    // receiver side: random stalls, plus one long hold on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        weight_t want;
        cycles = cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_ripley_box_edge_weight: errors");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", m_tdata);
                errors = errors + 1;
            end
            else
            begin
                want = pending_q.pop_front();
                n_results = n_results + 1;
                if (m_tuser[0])
                    n_sat = n_sat + 1;
                if (m_tdata !== want.weight)
                begin
                    $error("edge_weight expected %h actual %h", want.weight, m_tdata);
                    errors = errors + 1;
                end
                if (m_tuser[0] !== want.sat)
                begin
                    $error("weight_saturated expected %b actual %b", want.sat, m_tuser[0]);
                    errors = errors + 1;
                end
            end
        end
    end

    task automatic send_item(input row_t row);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, row.r, row.y, row.x};
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        pending_q.push_back(row.typed ? row.want : box_weight(row.x, row.y, row.r));
        n_items = n_items + 1;
    endtask

    task automatic sender_gap(input int n);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        case (idx)
            REG_X_MIN: box_x_min = val;
            REG_Y_MIN: box_y_min = val;
            REG_X_MAX: box_x_max = val;
            REG_Y_MAX: box_y_max = val;
            REG_TOL:   box_tol = val[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_box(input logic [31:0] x0, input logic [31:0] y0,
                           input logic [31:0] x1, input logic [31:0] y1,
                           input logic [31:0] tol);
        write_reg(REG_X_MIN, x0);
        write_reg(REG_Y_MIN, y0);
        write_reg(REG_X_MAX, x1);
        write_reg(REG_Y_MAX, y1);
        write_reg(REG_TOL, tol);
    endtask

    function automatic logic [31:0] near_coord(input logic signed [31:0] lo,
                                               input logic signed [31:0] hi,
                                               input longint reach);
        longint span;
        longint v;
        span = longint'(hi) - longint'(lo);
        if (span <= 0)
            span = 65536;
        case ($urandom_range(0, 5))
            0: v = longint'(lo) + longint'($urandom_range(0, 3)) - 1;
            1: v = longint'(hi) + longint'($urandom_range(0, 3)) - 1;
            2: v = longint'(lo) - longint'($urandom) % (reach + 1);
            default: v = longint'(lo) + longint'({$urandom, $urandom}
                         & 64'h7FFFFFFFFFFFFFFF) % (span + 1);
        endcase
        return v[31:0];
    endfunction

    function automatic row_t random_row();
        row_t   row;
        longint span;
        row.typed = 1'b0;
        row.want = '{32'h0, 1'b0};
        span = longint'(box_x_max) - longint'(box_x_min);
        if (span <= 0 || span > 64'h7FFFFFFF)
            span = 64'h7FFFFFFF;
        case ($urandom_range(0, 9))
            0:
            begin
                row.x = $urandom;
                row.y = $urandom;
                row.r = $urandom;
            end
            1:
            begin
                row.x = $urandom;
                row.y = $urandom;
                row.r = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom_range(0, 255));
            end
            default:
            begin
                row.r = 31'(longint'($urandom) % (span + 1));
                if ($urandom_range(0, 3) == 0)
                    row.r = 31'(longint'($urandom) % (span / 8 + 2));
                row.x = near_coord(box_x_min, box_x_max, row.r);
                row.y = near_coord(box_y_min, box_y_max, row.r);
            end
        endcase
        return row;
    endfunction

    task automatic random_phase(input int n, input bit with_hold);
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == 20)
                hold_req = 1'b1;
            if (!quiet && !(with_hold && i > 20 && i < 200) && $urandom_range(0, 5) == 0)
                sender_gap($urandom_range(1, 14));
            send_item(random_row());
        end
    endtask

    row_t directed[$];

    initial
    begin
        errors = 0;
        cycles = 0;
        n_items = 0;
        n_results = 0;
        n_sat = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_X_MIN;
        cfg_data = '0;
        box_x_min = 32'sd0;
        box_y_min = 32'sd0;
        box_x_max = 32'sd65536;
        box_y_max = 32'sd65536;
        box_tol = 16'd1;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // unit square after reset
        directed = '{
            '{32'h00008000, 32'h00008000, 31'd0,          1'b1, '{32'hFFFFFFFF, 1'b1}},
            '{32'h00008000, 32'h00008000, 31'h00001000,   1'b1, '{32'h01000000, 1'b0}},
            '{32'h80000000, 32'h7FFFFFFF, 31'd0,          1'b1, '{32'hFFFFFFFF, 1'b1}},
            '{32'h00008000, 32'h00008000, 31'h00000001,   1'b1, '{32'h01000000, 1'b0}},
            '{32'h00000000, 32'h00000000, 31'h00000100,   1'b0, '{32'h0, 1'b0}},
            '{32'h00010000, 32'h00010000, 31'h00000100,   1'b0, '{32'h0, 1'b0}},
            '{32'h00000000, 32'h00008000, 31'h00000100,   1'b0, '{32'h0, 1'b0}},
            '{32'h00008000, 32'h00010000, 31'h00004000,   1'b0, '{32'h0, 1'b0}},
            '{32'h00002000, 32'h00003000, 31'h00004000,   1'b0, '{32'h0, 1'b0}},
            '{32'h00008000, 32'h00008000, 31'h00008000,   1'b0, '{32'h0, 1'b0}},
            '{32'h00008000, 32'h00008000, 31'h0000C000,   1'b0, '{32'h0, 1'b0}},
            '{32'h00008000, 32'h00008000, 31'h7FFFFFFF,   1'b0, '{32'h0, 1'b0}},
            '{32'h80000000, 32'h80000000, 31'h00000010,   1'b0, '{32'h0, 1'b0}},
            '{32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,   1'b0, '{32'h0, 1'b0}},
            '{32'hFFFF0000, 32'h00008000, 31'h00020000,   1'b0, '{32'h0, 1'b0}},
            '{32'h00000000, 32'h00000000, 31'h00000000,   1'b1, '{32'hFFFFFFFF, 1'b1}},
            '{32'h00000001, 32'h00000000, 31'h00000002,   1'b0, '{32'h0, 1'b0}},
            '{32'hFFFFFFFF, 32'h00010001, 31'h00000003,   1'b0, '{32'h0, 1'b0}}
        };
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: ;
                1: set_box(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFF);
                2: set_box(32'hFFF00000, 32'h00000100, 32'h00100000, 32'h00000900, 32'h0);
                3: set_box(32'h00040000, 32'h00040000, 32'hFFFC0000, 32'hFFFC0000, 32'h10);
                4: set_box($urandom, $urandom, $urandom, $urandom, $urandom);
                default:
                begin
                    set_box(32'h00000000, 32'h00000000, 32'h00010000, 32'h00020000, 32'h100);
                    write_reg(REG_SPARE, 32'hDEADBEEF);
                    quiet = 1'b1;
                end
            endcase
            random_phase(PER_PHASE, p == 1);
            drain();
        end

        repeat (130)
            @(posedge clk);
        $display("covered %0d input transactions, %0d results (%0d saturated)",
                 n_items, n_results, n_sat);
        $display("over %0d rectangle settings, including a long output hold", NUM_PHASES);
        if (errors == 0 && pending_q.size() == 0)
            $display("tb_ripley_box_edge_weight: clean");
        else
            $display("tb_ripley_box_edge_weight: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hdl
hdl/rbe_pkg.sv
hdl/rbe_delay.sv
hdl/rbe_isqrt.sv
hdl/rbe_atan2.sv
hdl/rbe_div.sv
hdl/ripley_box_edge_weight.sv
sim/tb_ripley_box_edge_weight.sv
